[sv/tlpq_pkg.sv]
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants of the three-level strict-priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned LVL_N      = 3;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PRI_W      = 2;
  localparam int unsigned CMD_DEPTH  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SIZE    = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [PRI_W-1:0] PRI_HIGH   = 2'd3;
  localparam logic [PRI_W-1:0] PRI_MEDIUM = 2'd2;

  typedef enum logic [1:0] {
    LVL_HIGH   = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_LOW    = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e     op;
    level_e  level;
    status_e status;
  } cmd_ctrl_t;

endpackage

`default_nettype wire

[sv/tlpq_if.sv]
// ----------------------------------------------------------------------------
// tlpq interfaces
// Valid/ready channels for requests, responses and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpq_req_if #(
  parameter int unsigned VALUE_WIDTH = tlpq_pkg::VALUE_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [VALUE_WIDTH-1:0]       push_value;
  logic [tlpq_pkg::PRI_W-1:0]          priority_req;

  modport source (output valid, kind, push_value, priority_req, input ready);
  modport sink   (input valid, kind, push_value, priority_req, output ready);
endinterface

interface tlpq_rsp_if #(
  parameter int unsigned VALUE_WIDTH = tlpq_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] popped_value;
  logic [1:0]                    status;

  modport source (output valid, popped_value, status, input ready);
  modport sink   (input valid, popped_value, status, output ready);
endinterface

interface tlpq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tlpq_pkg::CFG_IDX_W-1:0]   index;
  logic [tlpq_pkg::SIZE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/tlpq_ram.sv]
// ----------------------------------------------------------------------------
// tlpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/tlpq_front.sv]
// ----------------------------------------------------------------------------
// tlpq_front
// Takes requests and size config writes, tracks head/tail/busy of each level
// and turns every request into one command with its final status.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_front #(
  parameter int unsigned LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = tlpq_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned ADDR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  tlpq_req_if.sink                       req_i,
  tlpq_cfg_if.sink                       cfg_i,
  output logic                           cmd_valid_o,
  input  wire logic                      cmd_ready_i,
  output tlpq_pkg::cmd_ctrl_t            cmd_ctrl_o,
  output logic [ADDR_W-1:0]              cmd_addr_o,
  output logic [VALUE_WIDTH-1:0]         cmd_value_o
);

  localparam int unsigned LN    = tlpq_pkg::LVL_N;
  localparam int unsigned CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > tlpq_pkg::SIZE_W) ? CNT_W : tlpq_pkg::SIZE_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LEVEL_DEPTH);

  logic [tlpq_pkg::SIZE_W-1:0] size_q [LN];
  logic [tlpq_pkg::SIZE_W-1:0] size_d [LN];
  logic [ADDR_W-1:0]           head_q [LN];
  logic [ADDR_W-1:0]           head_d [LN];
  logic [ADDR_W-1:0]           tail_q [LN];
  logic [ADDR_W-1:0]           tail_d [LN];
  logic [LN-1:0]               busy_q;
  logic [LN-1:0]               busy_d;

  logic [CMP_W-1:0]            eff    [LN];
  logic [CMP_W-1:0]            tail_inc [LN];
  logic [LN-1:0]               can_push;
  logic [LN-1:0]               push_sel;
  logic [LN-1:0]               pop_sel;
  tlpq_pkg::level_e            push_lvl;
  tlpq_pkg::level_e            pop_lvl;
  logic                        accept;

  assign accept      = req_i.valid && cmd_ready_i;
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;
  assign cfg_i.ready = 1'b1;

  // config writes
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      size_d[l] = size_q[l];
    end
    if (cfg_i.valid) begin
      if (cfg_i.index == tlpq_pkg::CFG_HIGH_SIZE) begin
        size_d[tlpq_pkg::LVL_HIGH] = cfg_i.data;
      end
      if (cfg_i.index == tlpq_pkg::CFG_MEDIUM_SIZE) begin
        size_d[tlpq_pkg::LVL_MEDIUM] = cfg_i.data;
      end
      if (cfg_i.index == tlpq_pkg::CFG_LOW_SIZE) begin
        size_d[tlpq_pkg::LVL_LOW] = cfg_i.data;
      end
    end
  end

  // per-level room check, size above depth acts as depth
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      eff[l]      = (CMP_W'(size_q[l]) > DEPTH_C) ? DEPTH_C : CMP_W'(size_q[l]);
      tail_inc[l] = CMP_W'(tail_q[l]) + CMP_W'(1);
      can_push[l] = busy_q[l] ? (tail_inc[l] < eff[l]) : (eff[l] != '0);
    end
  end

  // level selection
  always_comb begin
    push_sel = '0;
    if (req_i.priority_req == tlpq_pkg::PRI_HIGH) begin
      push_lvl = tlpq_pkg::LVL_HIGH;
    end else if (req_i.priority_req == tlpq_pkg::PRI_MEDIUM) begin
      push_lvl = tlpq_pkg::LVL_MEDIUM;
    end else begin
      push_lvl = tlpq_pkg::LVL_LOW;
    end
    push_sel[push_lvl] = 1'b1;

    pop_sel = '0;
    if (busy_q[tlpq_pkg::LVL_HIGH]) begin
      pop_lvl = tlpq_pkg::LVL_HIGH;
    end else if (busy_q[tlpq_pkg::LVL_MEDIUM]) begin
      pop_lvl = tlpq_pkg::LVL_MEDIUM;
    end else begin
      pop_lvl = tlpq_pkg::LVL_LOW;
    end
    pop_sel[pop_lvl] = busy_q[pop_lvl];
  end

  // command build and pointer update
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
    end
    busy_d            = busy_q;
    cmd_addr_o        = '0;
    cmd_value_o       = req_i.push_value;
    cmd_ctrl_o.op     = tlpq_pkg::OP_NONE;
    cmd_ctrl_o.level  = push_lvl;
    cmd_ctrl_o.status = tlpq_pkg::ST_DONE;

    if (req_i.kind == tlpq_pkg::KIND_PUSH) begin
      if (|(can_push & push_sel)) begin
        cmd_ctrl_o.op = tlpq_pkg::OP_WRITE;
        for (int l = 0; l < LN; l++) begin
          if (push_sel[l]) begin
            // first push into an empty level restarts at slot zero
            cmd_addr_o = busy_q[l] ? ADDR_W'(tail_inc[l]) : '0;
            if (accept) begin
              tail_d[l] = cmd_addr_o;
              busy_d[l] = 1'b1;
              if (!busy_q[l]) begin
                head_d[l] = '0;
              end
            end
          end
        end
      end else begin
        cmd_ctrl_o.status = tlpq_pkg::ST_FULL;
        cmd_value_o       = '0;
      end
    end else if (|busy_q) begin
      cmd_ctrl_o.op    = tlpq_pkg::OP_READ;
      cmd_ctrl_o.level = pop_lvl;
      for (int l = 0; l < LN; l++) begin
        if (pop_sel[l]) begin
          cmd_addr_o = head_q[l];
          if (accept) begin
            if (head_q[l] >= tail_q[l]) begin
              head_d[l] = '0;
              tail_d[l] = '0;
              busy_d[l] = 1'b0;
            end else begin
              head_d[l] = head_q[l] + ADDR_W'(1);
            end
          end
        end
      end
    end else begin
      cmd_ctrl_o.status = tlpq_pkg::ST_EMPTY;
      cmd_value_o       = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LN; l++) begin
        size_q[l] <= tlpq_pkg::SIZE_RESET;
        head_q[l] <= '0;
        tail_q[l] <= '0;
      end
      busy_q <= '0;
    end else begin
      for (int l = 0; l < LN; l++) begin
        size_q[l] <= size_d[l];
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
      end
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

[sv/tlpq_fifo.sv]
// ----------------------------------------------------------------------------
// tlpq_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tlpq_pkg::CMD_DEPTH,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/tlpq_back.sv]
// ----------------------------------------------------------------------------
// tlpq_back
// Executes queued read and write commands on the level memories and registers
// the response word of every command.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_back #(
  parameter int unsigned LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = tlpq_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned ADDR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  output logic                           cmd_ready_o,
  input  wire tlpq_pkg::cmd_ctrl_t       cmd_ctrl_i,
  input  wire logic [ADDR_W-1:0]         cmd_addr_i,
  input  wire logic [VALUE_WIDTH-1:0]    cmd_value_i,
  tlpq_rsp_if.source                     rsp_o
);

  localparam int unsigned LN = tlpq_pkg::LVL_N;

  logic                       issue;
  logic                       s1_adv;
  logic                       s1_valid_q;
  tlpq_pkg::cmd_ctrl_t        s1_ctrl_q;
  logic [VALUE_WIDTH-1:0]     s1_value_q;
  logic [VALUE_WIDTH-1:0]     rdata [LN];
  logic [VALUE_WIDTH-1:0]     s1_result;
  logic                       out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0]     out_value_q;
  tlpq_pkg::status_e          out_status_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign issue       = cmd_valid_i && (!s1_valid_q || s1_adv);
  assign cmd_ready_o = !s1_valid_q || s1_adv;

  for (genvar l = 0; l < LN; l++) begin : g_level
    tlpq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (LEVEL_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (issue && (cmd_ctrl_i.op == tlpq_pkg::OP_WRITE)
                      && (cmd_ctrl_i.level == tlpq_pkg::level_e'(l))),
      .waddr_i (cmd_addr_i),
      .wdata_i (cmd_value_i),
      .re_i    (issue && (cmd_ctrl_i.op == tlpq_pkg::OP_READ)
                      && (cmd_ctrl_i.level == tlpq_pkg::level_e'(l))),
      .raddr_i (cmd_addr_i),
      .rdata_o (rdata[l])
    );
  end

  // read data is held in the ram while this stage stalls
  always_comb begin
    case (s1_ctrl_q.op)
      tlpq_pkg::OP_READ: begin
        case (s1_ctrl_q.level)
          tlpq_pkg::LVL_HIGH:   s1_result = rdata[tlpq_pkg::LVL_HIGH];
          tlpq_pkg::LVL_MEDIUM: s1_result = rdata[tlpq_pkg::LVL_MEDIUM];
          default:              s1_result = rdata[tlpq_pkg::LVL_LOW];
        endcase
      end
      tlpq_pkg::OP_WRITE: s1_result = '0;
      default:            s1_result = s1_value_q;
    endcase
  end

  assign out_valid_d = s1_adv || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ctrl_q  <= cmd_ctrl_i;
      s1_value_q <= cmd_value_i;
    end
    if (s1_adv) begin
      out_value_q  <= s1_result;
      out_status_q <= s1_ctrl_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= issue || (s1_valid_q && !s1_adv);
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_value = out_value_q;
  assign rsp_o.status       = out_status_q;

endmodule

`default_nettype wire

[sv/three_level_priority_queue.sv]
// Path: command queue, then stage one of the back, then the response register.
// Throughput: one request per cycle; the front stalls only when the two-word
// command queue is full, which happens when the response side is held off.
// Stored pushes and data pops cost one memory access in the back; refused pushes
// and empty pops skip the memory but pass the same queue and registers.
// Reset: pointers and busy flags clear, sizes return to 16; memories are not cleared.
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict-priority queue with high, medium and low levels in linear buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_priority_queue #(
  parameter int unsigned LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = tlpq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tlpq_req_if.sink   req_i,
  tlpq_rsp_if.source rsp_o,
  tlpq_cfg_if.sink   cfg_i
);

  localparam int unsigned ADDR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CMD_W  = $bits(tlpq_pkg::cmd_ctrl_t) + ADDR_W + VALUE_WIDTH;

  logic                    f_valid, f_ready;
  tlpq_pkg::cmd_ctrl_t     f_ctrl;
  logic [ADDR_W-1:0]       f_addr;
  logic [VALUE_WIDTH-1:0]  f_value;
  logic                    b_valid, b_ready;
  logic [CMD_W-1:0]        b_word;
  tlpq_pkg::cmd_ctrl_t     b_ctrl;
  logic [ADDR_W-1:0]       b_addr;
  logic [VALUE_WIDTH-1:0]  b_value;

  tlpq_front #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_ctrl_o  (f_ctrl),
    .cmd_addr_o  (f_addr),
    .cmd_value_o (f_value)
  );

  tlpq_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (tlpq_pkg::CMD_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  ({f_ctrl, f_addr, f_value}),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_word)
  );

  assign {b_ctrl, b_addr, b_value} = b_word;

  tlpq_back #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_ctrl_i  (b_ctrl),
    .cmd_addr_i  (b_addr),
    .cmd_value_i (b_value),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

[sv/tlpq_checker.sv]
// ----------------------------------------------------------------------------
// tlpq_checker
// Port-level checks on the response channel of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_checker #(
  parameter int unsigned VALUE_WIDTH = tlpq_pkg::VALUE_WIDTH_DEF
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic [VALUE_WIDTH-1:0] rsp_value,
  input wire logic [1:0]             rsp_status
);

  // a held response word keeps its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
    else $error("response word changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_status == tlpq_pkg::ST_DONE) || (rsp_status == tlpq_pkg::ST_FULL)
                  || (rsp_status == tlpq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // empty pop answers all ones
  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status == tlpq_pkg::ST_EMPTY) |-> (rsp_value == '1))
    else $error("empty pop word is not all ones");

  a_full_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status == tlpq_pkg::ST_FULL) |-> (rsp_value == '0))
    else $error("refused push word is not zero");

endmodule

bind three_level_priority_queue tlpq_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tlpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_value  (rsp_o.popped_value),
  .rsp_status (rsp_o.status)
);

`default_nettype wire
